// ===== hdl/rsb_pkg.sv =====
package rsb_pkg;

   localparam int POS_W = 13;
   localparam int RIDX_W = 12;

   typedef logic [2:0] kind_type;

   localparam kind_type KIND_GET = 3'd0;
   localparam kind_type KIND_WRITE = 3'd1;
   localparam kind_type KIND_FLIP = 3'd2;
   localparam kind_type KIND_RANK = 3'd3;
   localparam kind_type KIND_SELECT = 3'd4;
   localparam kind_type KIND_NEXT = 3'd5;

   typedef struct packed {
      kind_type kind;
      logic [POS_W-1:0] position;
      logic write_value;
      logic [RIDX_W-1:0] rank_index;
      logic pos_ok;
      logic next_ok;
      logic rank_beyond;
      logic [5:0] bit_sel;
   } item_type;

   function automatic logic [3:0] pop8(input logic [7:0] x);
      logic [3:0] c;
      c = 4'd0;
      for (int j = 0; j < 8; j++) begin
         c = c + 4'(x[j]);
      end
      return c;
   endfunction

   function automatic logic [6:0] pop64(input logic [63:0] x);
      logic [6:0] c;
      c = 7'd0;
      for (int j = 0; j < 8; j++) begin
         c = c + 7'(pop8(x[j*8 +: 8]));
      end
      return c;
   endfunction

   function automatic logic [5:0] first_one(input logic [63:0] x);
      logic [2:0] byte_sel;
      logic [2:0] bit_sel;
      logic [7:0] byte_val;
      byte_sel = 3'd0;
      bit_sel = 3'd0;
      for (int j = 7; j >= 0; j--) begin
         if (x[j*8 +: 8] != 8'd0) begin
            byte_sel = 3'(j);
         end
      end
      byte_val = x[byte_sel*8 +: 8];
      for (int j = 7; j >= 0; j--) begin
         if (byte_val[j]) begin
            bit_sel = 3'(j);
         end
      end
      return {byte_sel, bit_sel};
   endfunction

endpackage

// ===== hdl/rsb_ram.sv =====
module rsb_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64,
   parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic clock,
   input  logic wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/rsb_front.sv =====
module rsb_front #(
   parameter int BIT_CAPACITY = 4096,
   parameter int SLATE_WORDS = 4
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  rsb_pkg::kind_type req_kind,
   input  logic [12:0] req_position,
   input  logic req_write_value,
   input  logic [11:0] req_rank_index,
   input  logic [12:0] size_n,
   output logic q_valid,
   input  logic q_pop,
   output rsb_pkg::item_type q_item,
   output logic [((((BIT_CAPACITY+63)/64) > 1) ? $clog2((BIT_CAPACITY+63)/64) : 1)-1:0] q_word,
   output logic [(((((BIT_CAPACITY+63)/64)+SLATE_WORDS-1)/SLATE_WORDS > 1) ?
      $clog2((((BIT_CAPACITY+63)/64)+SLATE_WORDS-1)/SLATE_WORDS) : 1)-1:0] q_slate,
   output logic [((SLATE_WORDS > 1) ? $clog2(SLATE_WORDS) : 1)-1:0] q_offs
);

   localparam int WORD_COUNT = (BIT_CAPACITY + 63) / 64;
   localparam int SLATE_COUNT = (WORD_COUNT + SLATE_WORDS - 1) / SLATE_WORDS;
   localparam int WIW = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
   localparam int SKW = (SLATE_COUNT > 1) ? $clog2(SLATE_COUNT) : 1;
   localparam int OW = (SLATE_WORDS > 1) ? $clog2(SLATE_WORDS) : 1;
   localparam int K = WIW + 8;
   localparam int PRW = WIW + K + 1;
   localparam longint RECIP = (64'd1 << K) / SLATE_WORDS;

   rsb_pkg::item_type item_ff [2];
   logic [WIW-1:0] word_ff [2];
   logic [SKW-1:0] slate_ff [2];
   logic [OW-1:0] offs_ff [2];
   logic wr_ptr_ff, wr_ptr_in;
   logic rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;

   rsb_pkg::item_type item_new;
   logic [12:0] pos1;
   logic [12:0] idx;
   logic [WIW-1:0] word_new;
   logic [PRW-1:0] prod;
   logic [WIW-1:0] slate_est;
   logic [WIW-1:0] rem_est;
   logic [WIW-1:0] slate_new;
   logic [WIW-1:0] rem_new;
   logic push;

   always_comb begin
      pos1 = (req_position == 13'd0) ? 13'd1 : req_position;
      idx = pos1 - 13'd1;
      word_new = WIW'(idx[12:6]);
      prod = PRW'(word_new) * PRW'(RECIP);
      slate_est = WIW'(prod >> K);
      rem_est = word_new - WIW'(slate_est * SLATE_WORDS);
      if (rem_est >= SLATE_WORDS) begin
         slate_new = slate_est + WIW'(1);
         rem_new = rem_est - WIW'(SLATE_WORDS);
      end else begin
         slate_new = slate_est;
         rem_new = rem_est;
      end
      item_new.kind = req_kind;
      item_new.position = req_position;
      item_new.write_value = req_write_value;
      item_new.rank_index = req_rank_index;
      item_new.pos_ok = (req_position != 13'd0) && (req_position <= size_n);
      item_new.next_ok = (req_position <= size_n) && (size_n != 13'd0);
      item_new.rank_beyond = req_position > size_n;
      item_new.bit_sel = idx[5:0];
   end

   assign req_ready = cnt_ff != 2'd2;
   assign push = req_valid && req_ready;
   assign q_valid = cnt_ff != 2'd0;
   assign q_item = item_ff[rd_ptr_ff];
   assign q_word = word_ff[rd_ptr_ff];
   assign q_slate = slate_ff[rd_ptr_ff];
   assign q_offs = offs_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         item_ff[wr_ptr_ff] <= item_new;
         word_ff[wr_ptr_ff] <= word_new;
         slate_ff[wr_ptr_ff] <= SKW'(slate_new);
         offs_ff[wr_ptr_ff] <= OW'(rem_new);
      end
   end

endmodule

// ===== hdl/rsb_back.sv =====
module rsb_back #(
   parameter int BIT_CAPACITY = 4096,
   parameter int SLATE_WORDS = 4
) (
   input  logic clock,
   input  logic reset,
   input  logic csr_we,
   input  logic [12:0] csr_wdata,
   output logic [12:0] size_n,
   input  logic q_valid,
   output logic q_pop,
   input  rsb_pkg::item_type q_item,
   input  logic [((((BIT_CAPACITY+63)/64) > 1) ? $clog2((BIT_CAPACITY+63)/64) : 1)-1:0] q_word,
   input  logic [(((((BIT_CAPACITY+63)/64)+SLATE_WORDS-1)/SLATE_WORDS > 1) ?
      $clog2((((BIT_CAPACITY+63)/64)+SLATE_WORDS-1)/SLATE_WORDS) : 1)-1:0] q_slate,
   input  logic [((SLATE_WORDS > 1) ? $clog2(SLATE_WORDS) : 1)-1:0] q_offs,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic rsp_bit_out,
   output logic [12:0] rsp_answer,
   output logic [12:0] rsp_ones_total
);

   localparam int WORD_COUNT = (BIT_CAPACITY + 63) / 64;
   localparam int SLATE_COUNT = (WORD_COUNT + SLATE_WORDS - 1) / SLATE_WORDS;
   localparam int WIW = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
   localparam int SKW = (SLATE_COUNT > 1) ? $clog2(SLATE_COUNT) : 1;
   localparam int SKCW = $clog2(SLATE_COUNT + 1);
   localparam int OW = (SLATE_WORDS > 1) ? $clog2(SLATE_WORDS) : 1;
   localparam int WKW = $clog2(WORD_COUNT + SLATE_WORDS + 1);
   localparam int SCW = $clog2(SLATE_WORDS * 64 + 1);
   localparam int FW = WKW + 7;

   typedef enum logic [3:0] {
      IDLE, LOOKUP, RANK_SLATE, RANK_RD, RANK_ACC, SEL_SLATE, SEL_RD, SEL_CHK,
      SEL_BYTE, SEL_BIT, NEXT_STEP, NEXT_CHK, FINISH
   } state_type;

   state_type state_ff, state_in;
   rsb_pkg::item_type item_ff, item_in;
   logic [WIW-1:0] word_ff, word_in;
   logic [SKW-1:0] slate_ff, slate_in;
   logic [OW-1:0] offs_ff, offs_in;
   logic [63:0] cur_ff, cur_in;
   logic [SKCW-1:0] sk_ff, sk_in;
   logic [WKW-1:0] wk_ff, wk_in;
   logic [OW-1:0] wi_ff, wi_in;
   logic [12:0] acc_ff, acc_in;
   logic [12:0] need_ff, need_in;
   logic [2:0] bj_ff, bj_in;
   logic [2:0] bt_ff, bt_in;
   logic [63:0] selw_ff, selw_in;
   logic [12:0] ans_ff, ans_in;
   logic bit_ff, bit_in;
   logic [12:0] size_ff, size_in;
   logic [12:0] ones_ff, ones_in;
   logic [WORD_COUNT-1:0] vld_ff, vld_in;
   logic rd_vld_ff, rd_vld_in;
   logic [SCW-1:0] sc_ff [SLATE_COUNT];
   logic [SCW-1:0] sc_in [SLATE_COUNT];
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_bit_ff, rsp_bit_in;
   logic [12:0] rsp_ans_ff, rsp_ans_in;
   logic [12:0] rsp_total_ff, rsp_total_in;

   logic ram_we;
   logic [63:0] ram_wdata;
   logic [WIW-1:0] ram_raddr;
   logic [63:0] ram_rdata;
   logic [63:0] rd_word;
   logic [SCW-1:0] sc_rd;
   logic [63:0] low_mask;
   logic new_bit;
   logic [63:0] new_word;
   logic [63:0] next_x;
   logic [FW-1:0] found_pos;
   logic [FW-1:0] sel_pos;
   logic [6:0] pc;
   logic [3:0] bc;
   logic sel_b;

   rsb_ram #(
      .WIDTH(64),
      .DEPTH(WORD_COUNT),
      .AW(WIW)
   ) u_words (
      .clock(clock),
      .wr_en(ram_we),
      .wr_addr(word_ff),
      .wr_data(ram_wdata),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   assign size_n = (32'(size_ff) > BIT_CAPACITY) ? 13'(BIT_CAPACITY) : size_ff;
   assign q_pop = (state_ff == IDLE) && q_valid;
   assign ram_raddr = (state_ff == IDLE) ? q_word : wk_ff[WIW-1:0];
   assign rd_word = rd_vld_ff ? ram_rdata : 64'd0;
   assign sc_rd = sc_ff[sk_ff[SKW-1:0]];
   assign low_mask = (64'd1 << item_ff.bit_sel) - 64'd1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_bit_out = rsp_bit_ff;
   assign rsp_answer = rsp_ans_ff;
   assign rsp_ones_total = rsp_total_ff;

   always_comb begin
      state_in = state_ff;
      item_in = item_ff;
      word_in = word_ff;
      slate_in = slate_ff;
      offs_in = offs_ff;
      cur_in = cur_ff;
      sk_in = sk_ff;
      wk_in = wk_ff;
      wi_in = wi_ff;
      acc_in = acc_ff;
      need_in = need_ff;
      bj_in = bj_ff;
      bt_in = bt_ff;
      selw_in = selw_ff;
      ans_in = ans_ff;
      bit_in = bit_ff;
      size_in = size_ff;
      ones_in = ones_ff;
      vld_in = vld_ff;
      sc_in = sc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_bit_in = rsp_bit_ff;
      rsp_ans_in = rsp_ans_ff;
      rsp_total_in = rsp_total_ff;
      ram_we = 1'b0;
      ram_wdata = rd_word;
      rd_vld_in = vld_ff[ram_raddr];

      new_bit = (item_ff.kind == rsb_pkg::KIND_WRITE) ? item_ff.write_value
                                                      : ~rd_word[item_ff.bit_sel];
      new_word = rd_word;
      new_word[item_ff.bit_sel] = new_bit;
      next_x = rd_word & ~low_mask;
      found_pos = {wk_ff, rsb_pkg::first_one(rd_word)} + FW'(1);
      if (state_ff == LOOKUP) begin
         found_pos = {WKW'(word_ff), rsb_pkg::first_one(next_x)} + FW'(1);
      end
      pc = rsb_pkg::pop64(rd_word);
      bc = rsb_pkg::pop8(selw_ff[bj_ff*8 +: 8]);
      sel_b = selw_ff[{bj_ff, bt_ff}];
      sel_pos = {wk_ff, bj_ff, bt_ff} + FW'(1);

      unique case (state_ff)
         IDLE: begin
            if (q_valid) begin
               item_in = q_item;
               word_in = q_word;
               slate_in = q_slate;
               offs_in = q_offs;
               sk_in = SKCW'(q_slate);
               ans_in = 13'd0;
               state_in = LOOKUP;
            end
         end
         LOOKUP: begin
            cur_in = rd_word;
            bit_in = item_ff.pos_ok && rd_word[item_ff.bit_sel];
            state_in = FINISH;
            case (item_ff.kind)
               rsb_pkg::KIND_WRITE, rsb_pkg::KIND_FLIP: begin
                  bit_in = item_ff.pos_ok && new_bit;
                  if (item_ff.pos_ok && (new_bit != rd_word[item_ff.bit_sel])) begin
                     ram_we = 1'b1;
                     ram_wdata = new_word;
                     vld_in[word_ff] = 1'b1;
                     if (new_bit) begin
                        sc_in[sk_ff[SKW-1:0]] = sc_rd + SCW'(1);
                        ones_in = ones_ff + 13'd1;
                     end else begin
                        sc_in[sk_ff[SKW-1:0]] = sc_rd - SCW'(1);
                        ones_in = ones_ff - 13'd1;
                     end
                  end
               end
               rsb_pkg::KIND_RANK: begin
                  if (item_ff.rank_beyond || (ones_ff == 13'd0)) begin
                     ans_in = ones_ff;
                  end else if (item_ff.position != 13'd0) begin
                     acc_in = 13'd0;
                     sk_in = '0;
                     state_in = RANK_SLATE;
                  end
               end
               rsb_pkg::KIND_SELECT: begin
                  if (13'(item_ff.rank_index) < ones_ff) begin
                     need_in = 13'(item_ff.rank_index) + 13'd1;
                     sk_in = '0;
                     wk_in = '0;
                     state_in = SEL_SLATE;
                  end
               end
               rsb_pkg::KIND_NEXT: begin
                  if (item_ff.next_ok) begin
                     if (next_x != 64'd0) begin
                        ans_in = (found_pos <= FW'(size_n)) ? 13'(found_pos) : 13'd0;
                     end else begin
                        wk_in = WKW'(word_ff) + WKW'(1);
                        if (offs_ff == OW'(SLATE_WORDS - 1)) begin
                           wi_in = '0;
                           sk_in = SKCW'(slate_ff) + SKCW'(1);
                        end else begin
                           wi_in = offs_ff + OW'(1);
                        end
                        state_in = NEXT_STEP;
                     end
                  end
               end
               default: begin
               end
            endcase
         end
         RANK_SLATE: begin
            if (sk_ff < SKCW'(slate_ff)) begin
               acc_in = acc_ff + 13'(sc_rd);
               sk_in = sk_ff + SKCW'(1);
            end else begin
               wk_in = WKW'(word_ff) - WKW'(offs_ff);
               state_in = RANK_RD;
            end
         end
         RANK_RD: begin
            if (wk_ff < WKW'(word_ff)) begin
               state_in = RANK_ACC;
            end else begin
               ans_in = acc_ff + 13'(rsb_pkg::pop64(cur_ff & low_mask));
               state_in = FINISH;
            end
         end
         RANK_ACC: begin
            acc_in = acc_ff + 13'(pc);
            wk_in = wk_ff + WKW'(1);
            state_in = RANK_RD;
         end
         SEL_SLATE: begin
            if (sk_ff >= SLATE_COUNT) begin
               state_in = FINISH;
            end else if (13'(sc_rd) < need_ff) begin
               need_in = need_ff - 13'(sc_rd);
               sk_in = sk_ff + SKCW'(1);
               wk_in = wk_ff + WKW'(SLATE_WORDS);
            end else begin
               state_in = SEL_RD;
            end
         end
         SEL_RD: begin
            state_in = (wk_ff >= WORD_COUNT) ? FINISH : SEL_CHK;
         end
         SEL_CHK: begin
            if (13'(pc) < need_ff) begin
               need_in = need_ff - 13'(pc);
               wk_in = wk_ff + WKW'(1);
               state_in = SEL_RD;
            end else begin
               selw_in = rd_word;
               bj_in = 3'd0;
               state_in = SEL_BYTE;
            end
         end
         SEL_BYTE: begin
            if (13'(bc) < need_ff) begin
               need_in = need_ff - 13'(bc);
               bj_in = bj_ff + 3'd1;
            end else begin
               bt_in = 3'd0;
               state_in = SEL_BIT;
            end
         end
         SEL_BIT: begin
            if (sel_b && (need_ff == 13'd1)) begin
               ans_in = 13'(sel_pos);
               state_in = FINISH;
            end else begin
               if (sel_b) begin
                  need_in = need_ff - 13'd1;
               end
               bt_in = bt_ff + 3'd1;
            end
         end
         NEXT_STEP: begin
            if ((wk_ff >= WORD_COUNT) || ({wk_ff, 6'd0} >= (WKW + 6)'(size_n))) begin
               state_in = FINISH;
            end else if ((wi_ff == '0) && (sc_rd == '0)) begin
               wk_in = wk_ff + WKW'(SLATE_WORDS);
               sk_in = sk_ff + SKCW'(1);
            end else begin
               state_in = NEXT_CHK;
            end
         end
         NEXT_CHK: begin
            if (rd_word != 64'd0) begin
               ans_in = (found_pos <= FW'(size_n)) ? 13'(found_pos) : 13'd0;
               state_in = FINISH;
            end else begin
               wk_in = wk_ff + WKW'(1);
               if (wi_ff == OW'(SLATE_WORDS - 1)) begin
                  wi_in = '0;
                  sk_in = sk_ff + SKCW'(1);
               end else begin
                  wi_in = wi_ff + OW'(1);
               end
               state_in = NEXT_STEP;
            end
         end
         FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_bit_in = bit_ff;
               rsp_ans_in = ans_ff;
               rsp_total_in = ones_ff;
               state_in = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase

      if (csr_we) begin
         size_in = csr_wdata;
         ones_in = 13'd0;
         vld_in = '0;
         for (int j = 0; j < SLATE_COUNT; j++) begin
            sc_in[j] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         size_ff <= 13'd4096;
         ones_ff <= 13'd0;
         vld_ff <= '0;
         rd_vld_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int j = 0; j < SLATE_COUNT; j++) begin
            sc_ff[j] <= '0;
         end
      end else begin
         state_ff <= state_in;
         size_ff <= size_in;
         ones_ff <= ones_in;
         vld_ff <= vld_in;
         rd_vld_ff <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         sc_ff <= sc_in;
      end
      item_ff <= item_in;
      word_ff <= word_in;
      slate_ff <= slate_in;
      offs_ff <= offs_in;
      cur_ff <= cur_in;
      sk_ff <= sk_in;
      wk_ff <= wk_in;
      wi_ff <= wi_in;
      acc_ff <= acc_in;
      need_ff <= need_in;
      bj_ff <= bj_in;
      bt_ff <= bt_in;
      selw_ff <= selw_in;
      ans_ff <= ans_in;
      bit_ff <= bit_in;
      rsp_bit_ff <= rsp_bit_in;
      rsp_ans_ff <= rsp_ans_in;
      rsp_total_ff <= rsp_total_in;
   end

   a_pop_needs_item: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid && (state_ff == IDLE))
      else $error("queue popped without an item");

   a_ones_bounded: assert property (@(posedge clock) disable iff (reset)
      ones_ff <= size_n)
      else $error("ones count exceeds map size");

   a_finish_delivers: assert property (@(posedge clock) disable iff (reset)
      (state_ff == FINISH) && !rsp_valid_ff |=> rsp_valid_ff && (state_ff == IDLE))
      else $error("finished request not delivered");

   a_lookup_after_pop: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> state_ff == LOOKUP)
      else $error("popped request not looked up");

endmodule

// ===== hdl/rank_select_bitmap_top.sv =====
// Channel    Dir  Handshake                Payload
// req_       in   req_valid / req_ready    kind, position, write_value, rank_index
// rsp_       out  rsp_valid / rsp_ready    bit_out, answer, ones_total
// csr_       in   csr_we                   csr_wdata (bits_in_use)
//
// Get, write and flip pass from the queue head through the LOOKUP and FINISH
// states to the result register. Rank, select and next-one walk the per-slate
// ones counts and then the words, one read at a time through the single read
// port of the word memory.
// Reset (synchronous) empties the map at once; a csr write does the same.
// A two-entry queue keeps taking requests while the result register stalls, until both entries are full.
module rank_select_bitmap_top #(
   parameter int BIT_CAPACITY = 4096,
   parameter int SLATE_WORDS = 4
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [2:0] req_kind,
   input  logic [12:0] req_position,
   input  logic req_write_value,
   input  logic [11:0] req_rank_index,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic rsp_bit_out,
   output logic [12:0] rsp_answer,
   output logic [12:0] rsp_ones_total,
   input  logic csr_we,
   input  logic [12:0] csr_wdata
);

   localparam int WORD_COUNT = (BIT_CAPACITY + 63) / 64;
   localparam int SLATE_COUNT = (WORD_COUNT + SLATE_WORDS - 1) / SLATE_WORDS;
   localparam int WIW = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
   localparam int SKW = (SLATE_COUNT > 1) ? $clog2(SLATE_COUNT) : 1;
   localparam int OW = (SLATE_WORDS > 1) ? $clog2(SLATE_WORDS) : 1;

   logic [12:0] size_n;
   logic q_valid;
   logic q_pop;
   rsb_pkg::item_type q_item;
   logic [WIW-1:0] q_word;
   logic [SKW-1:0] q_slate;
   logic [OW-1:0] q_offs;

   rsb_front #(
      .BIT_CAPACITY(BIT_CAPACITY),
      .SLATE_WORDS(SLATE_WORDS)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_kind(req_kind),
      .req_position(req_position),
      .req_write_value(req_write_value),
      .req_rank_index(req_rank_index),
      .size_n(size_n),
      .q_valid(q_valid),
      .q_pop(q_pop),
      .q_item(q_item),
      .q_word(q_word),
      .q_slate(q_slate),
      .q_offs(q_offs)
   );

   rsb_back #(
      .BIT_CAPACITY(BIT_CAPACITY),
      .SLATE_WORDS(SLATE_WORDS)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata),
      .size_n(size_n),
      .q_valid(q_valid),
      .q_pop(q_pop),
      .q_item(q_item),
      .q_word(q_word),
      .q_slate(q_slate),
      .q_offs(q_offs),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_bit_out(rsp_bit_out),
      .rsp_answer(rsp_answer),
      .rsp_ones_total(rsp_ones_total)
   );

endmodule
